FILE: src/colmap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package colmap_pkg;

    localparam int VAL_W  = 32;          // Q16.16 value and limit width
    localparam int LEN_W  = 9;           // map_length register width
    localparam int Q_W    = LEN_W;       // quotient bits kept by the divider
    localparam int DIP_W  = 15;          // integer part of a non-negative value
    localparam int DIFF_W = VAL_W + 1;   // value - limit_low
    localparam int PROD_W = DIFF_W + LEN_W + 1;
    localparam int AD_W   = VAL_W;       // |limit_high - limit_low|
    localparam int D2_W   = AD_W + 1;    // 2 * |den|
    localparam int REM_W  = PROD_W;      // dividend 2|num| + |den|
    localparam int CH_W   = 8;
    localparam int RGB_W  = 3 * CH_W;
    localparam int EA_W   = 8;           // entry_index width
    localparam int CFG_AW = 2;

    localparam logic signed [VAL_W-1:0] LIMIT_LOW_RST  = 32'sd0;
    localparam logic signed [VAL_W-1:0] LIMIT_HIGH_RST = 32'sd65536;
    localparam logic [LEN_W-1:0]        MAP_LEN_RST    = 9'd64;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SCALED = 2'd0,
        CFG_LOW    = 2'd1,
        CFG_HIGH   = 2'd2,
        CFG_LEN    = 2'd3
    } t_cfg_addr;

    typedef enum logic {
        REQ_MAP   = 1'b0,
        REQ_WRITE = 1'b1
    } t_req;

    // settled configuration as seen by the datapath
    typedef struct packed {
        logic                    scaled;
        logic signed [VAL_W-1:0] low;
        logic [LEN_W-1:0]        len;
        logic                    den_neg;
        logic                    den_zero;
        logic [AD_W-1:0]         ad;
    } t_cfg;

    // table write payload carried along the pipe
    typedef struct packed {
        logic             is_wr;
        logic [EA_W-1:0]  addr;
        logic [RGB_W-1:0] rgb;
    } t_wr;

    typedef struct packed {
        t_wr              wr;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             zero;
        logic             ovf;
        logic             skip;
    } t_div_item;

    typedef struct packed {
        t_wr              wr;
        logic [LEN_W-1:0] idx;
    } t_lut_item;

endpackage

`default_nettype wire

FILE: src/colormap_pixel_mapper_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Colormap pixel mapper.
// Input channel (i_valid / o_ready): one request per transfer. A map request
// (req_type 0) carries a signed Q16.16 pixel value; a table write (req_type 1)
// carries an entry index and its red, green and blue bytes and gives no result.
// Output channel (o_valid / i_ready): one RGB colour plus the clamped index per
// map request, in request order. Table writes travel the pipe in order with
// the maps, so a map sees every write transferred before it.
// Configuration: i_cfg_we writes register i_cfg_addr (scaled mode, low limit,
// high limit, map length) at once; change it only with the pipe empty.
// Pipeline: an input transfer passes three front stages, the restoring divider
// (overflow stage plus nine quotient-bit stages), the clamp register and the
// table read. Throughput is one request per cycle while the output is not
// stalled; every stage is registered and carries its own valid bit.
// Outside reset, an output stall backs up stage by stage; empty stages still
// fill, so o_ready drops only when every stage holds an item. Nothing is lost or
// repeated. Synchronous reset empties the pipe and loads the register defaults;
// the colour table keeps no reset value and must be written before use.

module colormap_pixel_mapper_top import colmap_pkg::*; #(
    parameter int MAP_DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_addr,
    input  logic [VAL_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_req_type,
    input  logic signed [VAL_W-1:0] i_pixel_value,
    input  logic [EA_W-1:0]         i_entry_index,
    input  logic [CH_W-1:0]         i_entry_red,
    input  logic [CH_W-1:0]         i_entry_green,
    input  logic [CH_W-1:0]         i_entry_blue,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CH_W-1:0]         o_red,
    output logic [CH_W-1:0]         o_green,
    output logic [CH_W-1:0]         o_blue,
    output logic [CH_W-1:0]         o_color_index
);

    // programmed registers
    logic                    r_scaled;
    logic signed [VAL_W-1:0] r_low;
    logic signed [VAL_W-1:0] r_high;
    logic [LEN_W-1:0]        r_map_len;

    // derived settings, refreshed every cycle; the pipe reads each one
    // only a few stages in, after it has settled
    logic signed [DIFF_W-1:0] r_den, n_den;
    logic [AD_W-1:0]          r_ad, n_ad;
    logic [LEN_W-1:0]         r_len, n_len;
    t_cfg                     w_cfg;

    logic      w_fr_ready, w_fr_valid;
    t_div_item w_fr_item;
    logic      w_div_ready, w_div_valid;
    t_lut_item w_div_item;
    logic      w_lut_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled  <= 1'b0;
            r_low     <= LIMIT_LOW_RST;
            r_high    <= LIMIT_HIGH_RST;
            r_map_len <= MAP_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_SCALED: r_scaled  <= i_cfg_data[0];
                CFG_LOW:    r_low     <= $signed(i_cfg_data);
                CFG_HIGH:   r_high    <= $signed(i_cfg_data);
                CFG_LEN:    r_map_len <= i_cfg_data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        n_den = $signed({r_high[VAL_W-1], r_high}) - $signed({r_low[VAL_W-1], r_low});
        if (r_den[DIFF_W-1]) begin
            n_ad = AD_W'(-r_den);
        end else begin
            n_ad = r_den[AD_W-1:0];
        end
        // zero length acts as one, beyond the table as the table size
        if (r_map_len == '0) begin
            n_len = LEN_W'(1);
        end else if (int'({1'b0, r_map_len}) > MAP_DEPTH) begin
            n_len = LEN_W'(MAP_DEPTH);
        end else begin
            n_len = r_map_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= n_den;
        r_ad  <= n_ad;
        r_len <= n_len;
    end

    always_comb begin
        w_cfg.scaled   = r_scaled;
        w_cfg.low      = r_low;
        w_cfg.len      = r_len;
        w_cfg.den_neg  = r_den[DIFF_W-1];
        w_cfg.den_zero = (r_den == '0);
        w_cfg.ad       = r_ad;
    end

    // no transfer is taken while reset is held
    assign o_ready = w_fr_ready && i_rst_n;

    colmap_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_valid),
        .o_ready       (w_fr_ready),
        .i_req_type    (i_req_type),
        .i_pixel_value (i_pixel_value),
        .i_entry_index (i_entry_index),
        .i_entry_red   (i_entry_red),
        .i_entry_green (i_entry_green),
        .i_entry_blue  (i_entry_blue),
        .o_valid       (w_fr_valid),
        .i_ready       (w_div_ready),
        .o_item        (w_fr_item)
    );

    colmap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d2    ({r_ad, 1'b0}),
        .i_len   (r_len),
        .i_valid (w_fr_valid),
        .o_ready (w_div_ready),
        .i_item  (w_fr_item),
        .o_valid (w_div_valid),
        .i_ready (w_lut_ready),
        .o_item  (w_div_item)
    );

    colmap_lut #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_lut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_div_valid),
        .o_ready       (w_lut_ready),
        .i_item        (w_div_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_color_index (o_color_index)
    );

`ifndef SYNTHESIS
    // outside reset, input is refused only while the output is valid and stalled
    a_refuse_only_when_full: assert property (@(posedge i_clk)
        i_rst_n && !o_ready |-> o_valid && !i_ready)
        else $error("input refused with room in the pipe");

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fr_valid && !w_div_ready |=> w_fr_valid && $stable(w_fr_item))
        else $error("front stage item lost or changed under stall");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_valid && !w_lut_ready |=> w_div_valid && $stable(w_div_item))
        else $error("divider item lost or changed under stall");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

FILE: src/colmap_front.sv
`timescale 1ns / 1ps
`default_nettype none

module colmap_front import colmap_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_req_type,
    input  logic signed [VAL_W-1:0] i_pixel_value,
    input  logic [EA_W-1:0]         i_entry_index,
    input  logic [CH_W-1:0]         i_entry_red,
    input  logic [CH_W-1:0]         i_entry_green,
    input  logic [CH_W-1:0]         i_entry_blue,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_div_item               o_item
);

    typedef struct packed {
        t_wr                      wr;
        logic                     scaled;
        logic                     dneg;
        logic [DIP_W-1:0]         dip;
        logic signed [DIFF_W-1:0] diff;
    } t_s1;

    typedef struct packed {
        t_wr                      wr;
        logic                     scaled;
        logic                     dneg;
        logic [DIP_W-1:0]         dip;
        logic signed [PROD_W-1:0] prod;
    } t_s2;

    logic      r_v1, r_v2, r_v3;
    t_s1       r_s1, n_s1;
    t_s2       r_s2, n_s2;
    t_div_item r_s3, n_s3;
    logic      w_rdy1, w_rdy2, w_rdy3;
    logic signed [PROD_W:0] w_n;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_item  = r_s3;

    // stage 1: offset from the lower limit, integer part for direct mode
    always_comb begin
        n_s1.wr.is_wr = (i_req_type == REQ_WRITE);
        n_s1.wr.addr  = i_entry_index;
        n_s1.wr.rgb   = {i_entry_red, i_entry_green, i_entry_blue};
        n_s1.scaled   = i_cfg.scaled;
        n_s1.dneg     = i_pixel_value[VAL_W-1];
        n_s1.dip      = i_pixel_value[VAL_W-2:VAL_W-1-DIP_W];
        n_s1.diff     = $signed({i_pixel_value[VAL_W-1], i_pixel_value})
                      - $signed({i_cfg.low[VAL_W-1], i_cfg.low});
    end

    // stage 2: scale by the table length
    always_comb begin
        n_s2.wr     = r_s1.wr;
        n_s2.scaled = r_s1.scaled;
        n_s2.dneg   = r_s1.dneg;
        n_s2.dip    = r_s1.dip;
        n_s2.prod   = $signed(r_s1.diff) * $signed({1'b0, i_cfg.len});
    end

    // stage 3: dividend 2|num| + |den| (scaled) or integer part as quotient (direct)
    always_comb begin
        if (r_s2.prod[PROD_W-1]) begin
            w_n = $signed({{(PROD_W+1-AD_W){1'b0}}, i_cfg.ad})
                - $signed({r_s2.prod, 1'b0});
        end else begin
            w_n = $signed({{(PROD_W+1-AD_W){1'b0}}, i_cfg.ad})
                + $signed({r_s2.prod, 1'b0});
        end
        n_s3.wr = r_s2.wr;
        if (!r_s2.scaled) begin
            n_s3.rem  = '0;
            n_s3.q    = r_s2.dip[Q_W-1:0];
            n_s3.ovf  = |r_s2.dip[DIP_W-1:Q_W];
            n_s3.zero = r_s2.dneg;
            n_s3.skip = 1'b1;
        end else begin
            n_s3.rem  = w_n[REM_W-1:0];
            n_s3.q    = '0;
            n_s3.ovf  = 1'b0;
            // opposite signs give a non-positive index
            n_s3.zero = i_cfg.den_zero || (r_s2.prod[PROD_W-1] != i_cfg.den_neg);
            n_s3.skip = n_s3.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_s1 <= n_s1;
        if (w_rdy2) r_s2 <= n_s2;
        if (w_rdy3) r_s3 <= n_s3;
    end

endmodule

`default_nettype wire

FILE: src/colmap_div.sv
`timescale 1ns / 1ps
`default_nettype none

module colmap_div import colmap_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [D2_W-1:0]  i_d2,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_div_item        i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output t_lut_item        o_item
);

    // overflow check, then one quotient bit per stage, MSB first
    localparam int NSTG = Q_W + 1;

    logic [NSTG-1:0]  r_v;
    t_div_item        r_it [NSTG];
    t_div_item        n_it [NSTG];
    t_div_item        w_src [NSTG];
    logic [NSTG-1:0]  w_src_v;
    logic [REM_W-1:0] w_sh [NSTG];
    logic [NSTG:0]    w_rdy;
    logic             r_cv;
    t_lut_item        r_ci, n_ci;
    t_div_item        w_last;

    always_comb begin
        w_rdy[NSTG] = !r_cv || i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_cv;
    assign o_item  = r_ci;

    always_comb begin
        w_src[0]   = i_item;
        w_src_v[0] = i_valid;
        for (int k = 1; k < NSTG; k++) begin
            w_src[k]   = r_it[k-1];
            w_src_v[k] = r_v[k-1];
        end

        w_sh[0] = REM_W'({i_d2, {Q_W{1'b0}}});
        n_it[0] = w_src[0];
        if (!w_src[0].skip && (w_src[0].rem >= w_sh[0])) begin
            n_it[0].ovf = 1'b1;
        end

        for (int k = 1; k < NSTG; k++) begin
            w_sh[k] = REM_W'(i_d2) << (Q_W - k);
            n_it[k] = w_src[k];
            if (!w_src[k].skip && !w_src[k].ovf && (w_src[k].rem >= w_sh[k])) begin
                n_it[k].rem = w_src[k].rem - w_sh[k];
                n_it[k].q   = w_src[k].q | (Q_W'(1) << (Q_W - k));
            end
        end
    end

    // clamp to 0..len-1
    always_comb begin
        w_last    = r_it[NSTG-1];
        n_ci.wr   = w_last.wr;
        if (w_last.zero) begin
            n_ci.idx = '0;
        end else if (w_last.ovf || (w_last.q >= i_len)) begin
            n_ci.idx = i_len - LEN_W'(1);
        end else begin
            n_ci.idx = w_last.q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_cv <= 1'b0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) r_v[k] <= w_src_v[k];
            end
            if (w_rdy[NSTG]) r_cv <= r_v[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_rdy[k]) r_it[k] <= n_it[k];
        end
        if (w_rdy[NSTG]) r_ci <= n_ci;
    end

endmodule

`default_nettype wire

FILE: src/colmap_lut.sv
`timescale 1ns / 1ps
`default_nettype none

module colmap_lut import colmap_pkg::*; #(
    parameter int MAP_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_lut_item       i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue,
    output logic [CH_W-1:0] o_color_index
);

    localparam int AW = $clog2(MAP_DEPTH);

    logic [RGB_W-1:0] r_mem [MAP_DEPTH];
    logic [RGB_W-1:0] r_rgb;
    logic [CH_W-1:0]  r_idx;
    logic             r_v;
    logic             w_ld;
    logic             w_in_range;

    assign w_ld       = !r_v || i_ready;
    assign w_in_range = int'({1'b0, i_item.wr.addr}) < MAP_DEPTH;
    assign o_ready    = w_ld;
    assign o_valid    = r_v;
    assign o_red      = r_rgb[RGB_W-1:2*CH_W];
    assign o_green    = r_rgb[2*CH_W-1:CH_W];
    assign o_blue     = r_rgb[CH_W-1:0];
    assign o_color_index = r_idx;

    // writes land here, in stream order with the reads
    always_ff @(posedge i_clk) begin
        if (w_ld && i_valid && i_item.wr.is_wr && w_in_range) begin
            r_mem[AW'(i_item.wr.addr)] <= i_item.wr.rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld && i_valid && !i_item.wr.is_wr) begin
            r_rgb <= r_mem[AW'(i_item.idx)];
            r_idx <= i_item.idx[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_ld) begin
            r_v <= i_valid && !i_item.wr.is_wr;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_colormap_pixel_mapper_top.sv
`timescale 1ns / 1ps

// Testbench for the colormap pixel mapper.
// Transfers on the request channel are driven at the falling edge, results are
// sampled at the rising edge. A local predictor tracks the colour table and the
// register settings and queues one expected colour per map request.

module tb_colormap_pixel_mapper_top import colmap_pkg::*;;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int MAP_DEPTH    = 256;
    localparam int IDLE_PCT     = 36;       // chance of an idle cycle, each side
    localparam int PIPE_SETTLE  = 24;       // longer than the pipe, covers trailing writes
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 128;

    // colour and index of one mapped pixel
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] idx;
    } t_colour;

    // DUT ports; the inputs are held at known values from time zero
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [VAL_W-1:0]  i_cfg_data    = '0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic              i_req_type    = 1'b0;
    logic [VAL_W-1:0]  i_pixel_value = '0;
    logic [EA_W-1:0]   i_entry_index = '0;
    logic [CH_W-1:0]   i_entry_red   = '0;
    logic [CH_W-1:0]   i_entry_green = '0;
    logic [CH_W-1:0]   i_entry_blue  = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [CH_W-1:0]   o_red;
    logic [CH_W-1:0]   o_green;
    logic [CH_W-1:0]   o_blue;
    logic [CH_W-1:0]   o_color_index;

    // predictor state: register copies and colour table
    bit                 map_scaled = 1'b0;
    longint             map_low    = 0;
    longint             map_high   = 65536;
    logic [LEN_W-1:0]   map_len    = MAP_LEN_RST;
    logic [RGB_W-1:0]   palette [MAP_DEPTH];

    t_colour pending_colours[$];

    bit idling      = 1'b1;     // random idle on both sides when set
    int n_errors    = 0;
    int n_maps      = 0;
    int n_writes    = 0;
    int n_settings  = 0;
    int cycle_count = 0;

    colormap_pixel_mapper_top #(
        .MAP_DEPTH(MAP_DEPTH)
    ) dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d colours outstanding",
                     cycle_count, pending_colours.size());
            $display("tb_colormap_pixel_mapper_top: FAIL");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_ready <= idling ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // Clamped table index for a pixel value under the current settings.
    // Scaled mode rounds halves away from zero; direct mode truncates to zero.
    function automatic logic [CH_W-1:0] predict_index(logic signed [VAL_W-1:0] value);
        longint v, len, den, num, an, ad, q, idx;
        v   = value;
        len = (map_len == 0) ? 1 : ((map_len > MAP_DEPTH) ? MAP_DEPTH : map_len);
        if (map_scaled) begin
            den = map_high - map_low;
            if (den == 0) begin
                idx = 0;                    // equal limits
            end else begin
                num = (v - map_low) * len;
                an  = (num < 0) ? -num : num;
                ad  = (den < 0) ? -den : den;
                q   = (2 * an + ad) / (2 * ad);
                idx = ((num < 0) != (den < 0)) ? -q : q;
            end
        end else begin
            idx = (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
        end
        if (idx < 0)
            idx = 0;
        if (idx >= len)
            idx = len - 1;
        return idx[CH_W-1:0];
    endfunction

    function automatic t_colour predict_colour(logic signed [VAL_W-1:0] value);
        t_colour c;
        c.idx = predict_index(value);
        {c.red, c.green, c.blue} = palette[c.idx];
        return c;
    endfunction

    // Result checker: each transfer against the oldest expected colour
    always @(posedge i_clk) begin : check_colours
        t_colour want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_colours.size() == 0) begin
                $error("result with nothing expected: index %0d rgb %02h%02h%02h",
                       o_color_index, o_red, o_green, o_blue);
                n_errors++;
            end else begin
                want = pending_colours.pop_front();
                if (o_red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_red);
                    n_errors++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_green);
                    n_errors++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_blue);
                    n_errors++;
                end
                if (o_color_index !== want.idx) begin
                    $error("color_index: expected %0d, got %0d", want.idx, o_color_index);
                    n_errors++;
                end
            end
        end
    end

    // One request transfer, with random idle cycles ahead of it.
    // Ends at the rising edge that accepts it; the predictor updates there.
    task automatic send_item(t_req req, logic [VAL_W-1:0] value, logic [EA_W-1:0] eidx,
                             logic [RGB_W-1:0] rgb);
        while (idling && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            i_valid       <= 1'b0;
            i_req_type    <= 1'($urandom_range(1));
            i_pixel_value <= $urandom;
            i_entry_index <= EA_W'($urandom);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_pixel_value <= value;
        i_entry_index <= eidx;
        {i_entry_red, i_entry_green, i_entry_blue} <= rgb;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (req == REQ_WRITE) begin
            palette[eidx] = rgb;
            n_writes++;
        end else begin
            pending_colours.push_back(predict_colour(value));
            n_maps++;
        end
    endtask

    // map fields other than the value are don't-care, so fill them at random
    task automatic map_pixel(logic [VAL_W-1:0] value);
        send_item(REQ_MAP, value, EA_W'($urandom), RGB_W'($urandom));
    endtask

    task automatic load_entry(logic [EA_W-1:0] eidx, logic [RGB_W-1:0] rgb);
        send_item(REQ_WRITE, $urandom, eidx, rgb);
    endtask

    // Stop sending and wait for the pipe to empty, trailing writes included
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_colours.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_addr addr, logic [VAL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
    endtask

    // Writes all four registers with the pipe idle
    task automatic set_config(bit scaled, logic signed [VAL_W-1:0] low,
                              logic signed [VAL_W-1:0] high, logic [LEN_W-1:0] len);
        drain();
        write_reg(CFG_SCALED, {{(VAL_W-1){1'b0}}, scaled});
        write_reg(CFG_LOW, low);
        write_reg(CFG_HIGH, high);
        write_reg(CFG_LEN, {{(VAL_W-LEN_W){1'b0}}, len});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        map_scaled = scaled;
        map_low    = low;
        map_high   = high;
        map_len    = len;
        n_settings++;
    endtask

    // Fill every entry before any map reads the table; extremes at both ends
    task automatic test_table_load();
        load_entry(8'd0, 24'h000000);
        for (int i = 1; i < MAP_DEPTH - 1; i++)
            load_entry(i[EA_W-1:0], RGB_W'($urandom));
        load_entry(8'd255, 24'hFFFFFF);
    endtask

    // Reset settings: direct mode, 64 entries
    task automatic test_direct_mode();
        map_pixel(32'h0000_0000);
        map_pixel(32'hFFFF_FFFF);           // -1 lsb truncates to 0
        map_pixel(32'h7FFF_FFFF);
        map_pixel(32'h8000_0000);
        map_pixel(32'h003F_FFFF);           // 63.99 -> 63
        map_pixel(32'h0040_0000);           // 64 clamps to 63
        map_pixel(32'hFFFE_8000);           // -1.5 truncates to -1, clamps to 0
        map_pixel(32'h0001_8000);           // 1.5 -> 1
        load_entry(8'd1, RGB_W'($urandom)); // map right after must see the new colour
        map_pixel(32'h0001_0000);
    endtask

    // map_length of 0 acts as 1, above the depth acts as the depth
    task automatic test_length_limits();
        set_config(1'b0, 32'sd0, 32'sd65536, 9'd0);
        map_pixel(32'h0005_0000);
        set_config(1'b0, 32'sd0, 32'sd65536, 9'd511);
        map_pixel(32'h012C_0000);
        map_pixel(32'h00FF_FFFF);
        set_config(1'b0, 32'sd0, 32'sd65536, 9'd256);
        map_pixel(32'h00C8_0000);
        set_config(1'b0, 32'sd0, 32'sd65536, 9'd1);
        map_pixel(32'h0007_0000);
    endtask

    task automatic test_scaled_mode();
        // one entry per unit: exact halves round away from zero
        set_config(1'b1, 32'sd0, 32'sh0040_0000, 9'd64);
        map_pixel(32'h0000_8000);
        map_pixel(32'h0000_7FFF);
        map_pixel(32'h0001_8000);
        map_pixel(32'hFFFF_8000);
        map_pixel(32'h003F_8000);
        // reversed limits
        set_config(1'b1, 32'sh0040_0000, 32'sd0, 9'd64);
        map_pixel(32'h0000_0000);
        map_pixel(32'h0020_0000);
        // equal limits
        set_config(1'b1, 32'sd12345, 32'sd12345, 9'd64);
        map_pixel(32'd12345);
        map_pixel(32'h7FFF_FFFF);
        // widest span
        set_config(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 9'd256);
        map_pixel(32'h8000_0000);
        map_pixel(32'h7FFF_FFFF);
        map_pixel(32'h0000_0000);
    endtask

    // Value aimed at the live index range most of the time, else edges or noise
    function automatic logic [VAL_W-1:0] pick_value();
        longint v, span;
        int     len_eff, pick;
        len_eff = (map_len == 0) ? 1 : ((map_len > MAP_DEPTH) ? MAP_DEPTH : map_len);
        pick    = $urandom_range(99);
        if (pick < 60) begin
            if (map_scaled) begin
                span = map_high - map_low;
                v = map_low + span * (int'($urandom_range(320)) - 32) / 256
                    + int'($urandom_range(64)) - 32;
            end else begin
                v = longint'(int'($urandom_range(len_eff + 8)) - 4) * 65536
                    + $urandom_range(65535);
            end
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return v[VAL_W-1:0];
        end
        if (pick < 72) begin
            case ($urandom_range(5))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return map_low[VAL_W-1:0];
                default: return map_high[VAL_W-1:0];
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_config(int phase);
        logic [LEN_W-1:0]        len;
        logic signed [VAL_W-1:0] lo, hi;
        int                      base;
        case ($urandom_range(5))
            0: len = 9'd1;
            1: len = 9'd256;
            2: len = LEN_W'($urandom_range(511, 257));
            3: len = 9'd0;
            default: len = LEN_W'($urandom_range(255, 2));
        endcase
        case ($urandom_range(5))
            0: begin
                lo = $urandom;
                hi = $urandom;
            end
            1: begin
                lo = 32'sh8000_0000;
                hi = 32'sh7FFF_FFFF;
            end
            2: begin
                lo = 32'sh7FFF_FFFF;
                hi = 32'sh8000_0000;
            end
            3: begin
                lo = $urandom;
                hi = lo;
            end
            default: begin
                base = int'($urandom_range(13107200)) - 6553600;
                lo   = base;
                hi   = base + int'($urandom_range(26214400)) - 6553600;
            end
        endcase
        // alternate modes from phase to phase
        set_config(phase[0], lo, hi, len);
    endtask

    // Random stream: mostly maps, table rewrites mixed in, new settings per phase
    task automatic test_random_stream();
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            random_config(phase);
            idling = (phase != 3);          // one phase runs flat out both ways
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 6 && n == PHASE_ITEMS / 2)
                    drain();                // sender holds until all colours are back
                if ($urandom_range(99) < 12)
                    load_entry(EA_W'($urandom), RGB_W'($urandom));
                else
                    map_pixel(pick_value());
            end
        end
        idling = 1'b1;
    endtask

    initial begin
        foreach (palette[i])
            palette[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_direct_mode();
        test_length_limits();
        test_scaled_mode();
        test_random_stream();
        drain();

        if (pending_colours.size() != 0) begin
            $error("%0d expected colours never arrived", pending_colours.size());
            n_errors++;
        end
        $display("Run covered %0d pixel maps and %0d table writes under %0d register settings,",
                 n_maps, n_writes, n_settings);
        $display("direct and scaled modes, length and limit extremes, with random idling.");
        if (n_errors == 0) begin
            $display("tb_colormap_pixel_mapper_top: PASS");
        end else begin
            $display("tb_colormap_pixel_mapper_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: colormap_pixel_mapper_top.f
src/colmap_pkg.sv
src/colmap_front.sv
src/colmap_div.sv
src/colmap_lut.sv
src/colormap_pixel_mapper_top.sv
test/tb_colormap_pixel_mapper_top.sv
